@@ hdl/arpc_pkg.sv @@
// shared types and codes for the arp cache
package arpc_pkg;
   localparam int unsigned TableEntriesDefault = 16;
   localparam logic [31:0] ValidPeriodReset = 32'd300000;
   localparam logic [31:0] WaitTimeoutReset = 32'd1000;

   localparam logic [1:0] CMD_LOOKUP   = 2'd0;
   localparam logic [1:0] CMD_REFRESH  = 2'd1;
   localparam logic [1:0] CMD_REGISTER = 2'd2;

   localparam logic [1:0] ST_INVALID = 2'd0;
   localparam logic [1:0] ST_VALID   = 2'd1;
   localparam logic [1:0] ST_WAIT    = 2'd2;

   localparam logic [1:0] CSR_VALID_PERIOD = 2'd0;
   localparam logic [1:0] CSR_WAIT_TIMEOUT = 2'd1;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic        kind;
      logic [1:0]  status;
      logic [31:0] stamp;
   } entry_type;
endpackage

@@ hdl/arp_cache_table_with_aging.sv @@
// arp cache top level: ring of entry cells and the scan sequencer
// Usage: an item on the req_ channel is a lookup, refresh or register command.
// It is taken when req_valid is high and req_stall is low; req_stall stays high
// while a command is being processed and until its result is taken.
// The entries sit in a ring of cells that rotates one place per cycle while
// a command is scanned or written; the head cell is examined and optionally
// rewritten as it passes. Lookup and refresh scan the ring once and then go
// to the result state; register scans it to pick the target, rotates it
// again to write that entry, and then goes to the result state.
// The result appears on rsp_ with rsp_valid and is held while rsp_stall is
// high; no new command is taken until it is delivered.
// The csr_ port writes valid_period (index 0) or wait_timeout (index 1); it is
// always ready, and writes to other indexes are ignored.
// Reset clears every entry to invalid with zero fields and restores the
// default timeouts.
module arp_cache_table_with_aging #(
   parameter int unsigned TABLE_ENTRIES = arpc_pkg::TableEntriesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_ip_addr,
   input  logic [47:0] req_mac_addr,
   input  logic        req_mac_present,
   input  logic        req_entry_type,
   input  logic [1:0]  req_entry_state,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [47:0] rsp_mac_out,
   output logic [3:0]  rsp_slot,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import arpc_pkg::*;

   localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES - 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_WRITE = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0] vp_ff, wt_ff;
   logic [1:0]  cmd_ff;
   logic [31:0] ip_ff, now_ff;
   logic [47:0] mac_ff;
   logic        has_mac_ff, kind_ff;
   logic [1:0]  st_ff;
   logic        found_ff, found_in, fip_ff, fip_in, ffree_ff, ffree_in;
   logic [IW-1:0] ipidx_ff, ipidx_in, freeidx_ff, freeidx_in, oldidx_ff, oldidx_in;
   logic [IW-1:0] target_ff, target_in;
   logic [31:0] oldest_ff, oldest_in;
   logic [1:0]  status_ff, status_in;
   logic [47:0] macout_ff, macout_in;
   logic [3:0]  slot_ff, slot_in;

   entry_type   q [TABLE_ENTRIES];
   entry_type   head, head_mod;
   logic        shift_en;
   logic [IW-1:0] idx;
   logic        live, match, expired;
   logic [31:0] age;

   assign shift_en = (state_ff == S_SCAN) || (state_ff == S_WRITE);
   assign head = q[0];

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_ring
      entry_type d;
      if (i == TABLE_ENTRIES - 1) begin : g_tail
         assign d = head_mod;
      end else begin : g_mid
         assign d = q[i+1];
      end
      arpc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .d_in     (d),
         .q        (q[i])
      );
   end

   assign idx     = cnt_ff[IW-1:0];
   assign live    = (head.status != ST_INVALID);
   assign match   = (head.ip == ip_ff);
   assign age     = now_ff - head.stamp;
   assign expired = (head.status == ST_VALID) ? (age > vp_ff) : (age > wt_ff);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      head_mod   = head;
      found_in   = found_ff;
      fip_in     = fip_ff;
      ipidx_in   = ipidx_ff;
      ffree_in   = ffree_ff;
      freeidx_in = freeidx_ff;
      oldest_in  = oldest_ff;
      oldidx_in  = oldidx_ff;
      target_in  = target_ff;
      status_in  = status_ff;
      macout_in  = macout_ff;
      slot_in    = slot_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in   = S_SCAN;
               cnt_in     = '0;
               found_in   = 1'b0;
               fip_in     = 1'b0;
               ffree_in   = 1'b0;
               oldest_in  = '0;
               oldidx_in  = '0;
               ipidx_in   = '0;
               freeidx_in = '0;
               status_in  = ST_INVALID;
               macout_in  = '0;
               slot_in    = '0;
            end
         end
         S_SCAN: begin
            case (cmd_ff)
               CMD_LOOKUP: begin
                  if (!found_ff && live && match) begin
                     found_in = 1'b1;
                     if (expired) begin
                        head_mod.status = ST_INVALID;
                     end else begin
                        status_in = head.status;
                        macout_in = (head.status == ST_VALID) ? head.mac : '0;
                        slot_in   = 4'(idx);
                     end
                  end
               end
               CMD_REFRESH: begin
                  if (!found_ff && live && match) begin
                     found_in        = 1'b1;
                     head_mod.stamp  = now_ff;
                     head_mod.status = ST_VALID;
                     status_in       = ST_VALID;
                     slot_in         = 4'(idx);
                  end
               end
               CMD_REGISTER: begin
                  if (!fip_ff && match) begin
                     fip_in   = 1'b1;
                     ipidx_in = idx;
                  end
                  if (!ffree_ff && (!live || expired)) begin
                     ffree_in   = 1'b1;
                     freeidx_in = idx;
                  end
                  if (age > oldest_ff) begin
                     oldest_in = age;
                     oldidx_in = idx;
                  end
               end
               default: begin
               end
            endcase
            if (cnt_ff == LAST) begin
               cnt_in = '0;
               if (cmd_ff == CMD_REGISTER) begin
                  state_in  = S_WRITE;
                  target_in = fip_in ? ipidx_in : (ffree_in ? freeidx_in : oldidx_in);
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_WRITE: begin
            if (idx == target_ff) begin
               head_mod.ip     = ip_ff;
               head_mod.kind   = kind_ff;
               head_mod.status = st_ff;
               head_mod.stamp  = now_ff;
               if (has_mac_ff) begin
                  head_mod.mac = mac_ff;
               end
               status_in = ST_VALID;
               slot_in   = 4'(idx);
            end
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = S_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         vp_ff    <= ValidPeriodReset;
         wt_ff    <= WaitTimeoutReset;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_valid && csr_index == CSR_VALID_PERIOD) begin
            vp_ff <= csr_wdata;
         end
         if (csr_valid && csr_index == CSR_WAIT_TIMEOUT) begin
            wt_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         cmd_ff     <= req_cmd;
         ip_ff      <= req_ip_addr;
         now_ff     <= req_now_ms;
         mac_ff     <= req_mac_addr;
         has_mac_ff <= req_mac_present;
         kind_ff    <= req_entry_type;
         st_ff      <= (req_entry_state == 2'd3) ? ST_WAIT : req_entry_state;
      end
      found_ff   <= found_in;
      fip_ff     <= fip_in;
      ipidx_ff   <= ipidx_in;
      ffree_ff   <= ffree_in;
      freeidx_ff <= freeidx_in;
      oldest_ff  <= oldest_in;
      oldidx_ff  <= oldidx_in;
      target_ff  <= target_in;
      status_ff  <= status_in;
      macout_ff  <= macout_in;
      slot_ff    <= slot_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = (state_ff == S_RESP);
   assign rsp_status  = status_ff;
   assign rsp_mac_out = macout_ff;
   assign rsp_slot    = slot_ff;
   assign csr_ready   = 1'b1;

`ifndef SYNTH
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LAST) else $error("scan counter out of range");
   a_scan_wraps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && cnt_ff == LAST) |=>
      (state_ff == S_WRITE || state_ff == S_RESP)) else $error("scan did not end");
   a_write_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && $past(state_ff) == S_WRITE) |-> (rsp_status == ST_VALID))
      else $error("register wrote no entry");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("item taken while result pending");
`endif
endmodule

@@ hdl/arpc_cell.sv @@
// one table entry in the rotating ring
module arpc_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  arpc_pkg::entry_type d_in,
   output arpc_pkg::entry_type q
);
   import arpc_pkg::*;

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (shift_en) begin
         entry_ff <= d_in;
      end
   end

   assign q = entry_ff;
endmodule

@@ tb/sv/tb.sv @@
// testbench for the arp cache: random and directed commands checked against a behavioral table
`timescale 1ns / 100ps
module tb;
   import arpc_pkg::*;

   localparam int N = 16;
   localparam longint unsigned CYCLE_LIMIT = 400000;

   typedef struct {
      logic [1:0]  cmd;
      logic [31:0] ip;
      logic [47:0] mac;
      logic        has_mac;
      logic        kind;
      logic [1:0]  st;
      logic [31:0] now;
   } arp_item_type;

   typedef struct {
      logic [1:0]  status;
      logic [47:0] mac;
      logic [3:0]  slot;
   } arp_result_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_cmd = 0;
   logic [31:0] req_ip_addr = 0;
   logic [47:0] req_mac_addr = 0;
   logic        req_mac_present = 0;
   logic        req_entry_type = 0;
   logic [1:0]  req_entry_state = 0;
   logic [31:0] req_now_ms = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [47:0] rsp_mac_out;
   logic [3:0]  rsp_slot;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = 0;
   logic [31:0] csr_wdata = 0;

   arp_cache_table_with_aging DUT (.*);

   arp_item_type   pending_items[$];
   arp_result_type expected_results[$];
   int          mismatches = 0;
   int          n_sent = 0, n_checked = 0, n_cfg = 0;
   longint unsigned cycles = 0;
   bit          no_idle = 0;

   logic [31:0] valid_period_m, wait_timeout_m;
   logic [31:0] tbl_ip[N];
   logic [47:0] tbl_mac[N];
   logic        tbl_kind[N];
   logic [1:0]  tbl_status[N];
   logic [31:0] tbl_time[N];

   initial forever #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic bit entry_expired(int i, logic [31:0] now);
      logic [31:0] age;
      age = now - tbl_time[i];
      if (tbl_status[i] == ST_VALID) return age > valid_period_m;
      return age > wait_timeout_m;
   endfunction

   function automatic arp_result_type apply_arp_cmd(arp_item_type it);
      arp_result_type r;
      int target;
      logic [31:0] oldest, age;
      logic [1:0] st;
      r = '{2'd0, 48'd0, 4'd0};
      st = (it.st == 2'd3) ? ST_WAIT : it.st;
      if (it.cmd == CMD_LOOKUP) begin
         for (int i = 0; i < N; i++) begin
            if (tbl_status[i] != ST_INVALID && tbl_ip[i] == it.ip) begin
               if (entry_expired(i, it.now)) tbl_status[i] = ST_INVALID;
               else if (tbl_status[i] == ST_VALID) r = '{ST_VALID, tbl_mac[i], 4'(i)};
               else r = '{ST_WAIT, 48'd0, 4'(i)};
               break;
            end
         end
      end else if (it.cmd == CMD_REFRESH) begin
         for (int i = 0; i < N; i++) begin
            if (tbl_status[i] != ST_INVALID && tbl_ip[i] == it.ip) begin
               tbl_time[i] = it.now;
               tbl_status[i] = ST_VALID;
               r = '{2'd1, 48'd0, 4'(i)};
               break;
            end
         end
      end else if (it.cmd == CMD_REGISTER) begin
         target = N;
         for (int i = 0; i < N; i++)
            if (tbl_ip[i] == it.ip) begin
               target = i;
               break;
            end
         if (target == N)
            for (int i = 0; i < N; i++) begin
               if (tbl_status[i] == ST_INVALID) begin
                  target = i;
                  break;
               end
               if (entry_expired(i, it.now)) begin
                  tbl_status[i] = ST_INVALID;
                  target = i;
                  break;
               end
            end
         if (target == N) begin
            oldest = 0;
            target = 0;
            for (int i = 0; i < N; i++) begin
               age = it.now - tbl_time[i];
               if (age > oldest) begin
                  oldest = age;
                  target = i;
               end
            end
         end
         tbl_kind[target] = it.kind;
         tbl_ip[target] = it.ip;
         tbl_status[target] = st;
         tbl_time[target] = it.now;
         if (it.has_mac) tbl_mac[target] = it.mac;
         r = '{2'd1, 48'd0, 4'(target)};
      end
      return r;
   endfunction

   task automatic report(string what, logic [47:0] got, logic [47:0] want);
      mismatches++;
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(apply_arp_cmd('{req_cmd, req_ip_addr, req_mac_addr,
               req_mac_present, req_entry_type, req_entry_state, req_now_ms}));
            n_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 17)) begin
               req_valid <= 1;
               req_cmd <= pending_items[0].cmd;
               req_ip_addr <= pending_items[0].ip;
               req_mac_addr <= pending_items[0].mac;
               req_mac_present <= pending_items[0].has_mac;
               req_entry_type <= pending_items[0].kind;
               req_entry_state <= pending_items[0].st;
               req_now_ms <= pending_items[0].now;
               void'(pending_items.pop_front());
            end else
               req_valid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0)
               report("unexpected item", 48'(rsp_status), 48'd0);
            else begin
               if (rsp_status !== expected_results[0].status)
                  report("status", 48'(rsp_status), 48'(expected_results[0].status));
               if (rsp_mac_out !== expected_results[0].mac)
                  report("mac_out", rsp_mac_out, expected_results[0].mac);
               if (rsp_slot !== expected_results[0].slot)
                  report("slot", 48'(rsp_slot), 48'(expected_results[0].slot));
               void'(expected_results.pop_front());
               n_checked++;
            end
         end
         rsp_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 17);
      end
   end

   task automatic queue_cmd(logic [1:0] c, logic [31:0] ip, logic [47:0] mac, logic hm,
                            logic k, logic [1:0] s, logic [31:0] now);
      pending_items.push_back('{c, ip, mac, hm, k, s, now});
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      if (idx == CSR_VALID_PERIOD) valid_period_m = val;
      else if (idx == CSR_WAIT_TIMEOUT) wait_timeout_m = val;
      n_cfg++;
      @(posedge clock);
   endtask

   // mostly a small pool of addresses and times near the limits so hits and expiry happen
   task automatic queue_random(int count, logic [31:0] span);
      logic [31:0] ip, now;
      logic [1:0] c;
      now = $urandom;
      for (int k = 0; k < count; k++) begin
         ip = ($urandom_range(9) == 0) ? $urandom : 32'(32'h0a000000 + $urandom_range(23));
         if ($urandom_range(49) == 0) c = 2'd3;
         else c = 2'($urandom_range(2));
         now = now + $urandom_range(span);
         if ($urandom_range(19) == 0) now = $urandom;
         queue_cmd(c, ip, 48'({$urandom, $urandom}), 1'($urandom), 1'($urandom),
                   2'($urandom), now);
      end
   endtask

   initial begin
      valid_period_m = ValidPeriodReset;
      wait_timeout_m = WaitTimeoutReset;
      for (int i = 0; i < N; i++) begin
         tbl_ip[i] = 0; tbl_mac[i] = 0; tbl_kind[i] = 0;
         tbl_status[i] = ST_INVALID; tbl_time[i] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed: zero ip reuse, limits, expiry, unknown cmd, state three
      queue_cmd(CMD_LOOKUP, 32'd0, 48'd0, 1'b0, 1'b0, 2'd0, 32'd0);
      queue_cmd(CMD_REFRESH, 32'd5, 48'd0, 1'b0, 1'b0, 2'd0, 32'd0);
      queue_cmd(CMD_REGISTER, 32'd0, 48'hffffffffffff, 1'b1, 1'b1, ST_VALID, 32'hffffffff);
      queue_cmd(CMD_LOOKUP, 32'd0, 48'd0, 1'b0, 1'b0, 2'd0, 32'd299999);
      queue_cmd(CMD_LOOKUP, 32'd0, 48'd0, 1'b0, 1'b0, 2'd0, 32'd300000);
      queue_cmd(CMD_REGISTER, 32'hffffffff, 48'h123456789abc, 1'b1, 1'b0, 2'd3, 32'd100);
      queue_cmd(CMD_LOOKUP, 32'hffffffff, 48'd0, 1'b0, 1'b0, 2'd0, 32'd1100);
      queue_cmd(CMD_REGISTER, 32'hffffffff, 48'h0, 1'b0, 1'b1, ST_VALID, 32'd1200);
      queue_cmd(CMD_LOOKUP, 32'hffffffff, 48'd0, 1'b0, 1'b0, 2'd0, 32'd1200);
      queue_cmd(CMD_REFRESH, 32'hffffffff, 48'd0, 1'b0, 1'b0, 2'd0, 32'd900000);
      queue_cmd(2'd3, 32'hffffffff, 48'hffffffffffff, 1'b1, 1'b1, 2'd3, 32'hffffffff);
      queue_cmd(CMD_LOOKUP, 32'hffffffff, 48'd0, 1'b0, 1'b0, 2'd0, 32'd900000);
      queue_cmd(CMD_REGISTER, 32'h7, 48'h1, 1'b1, 1'b0, ST_INVALID, 32'd5);
      for (int i = 0; i < 10; i++)
         queue_cmd(CMD_REGISTER, 32'(32'h100 + i), 48'(i), 1'b1, 1'b0, ST_WAIT,
                   32'(32'd10 + i));
      drain();

      write_csr(CSR_VALID_PERIOD, 32'd0);
      write_csr(CSR_WAIT_TIMEOUT, 32'hffffffff);
      write_csr(2'd3, 32'd55);
      no_idle = 1;
      queue_random(200, 3);
      drain();
      no_idle = 0;

      write_csr(CSR_VALID_PERIOD, 32'd40);
      write_csr(CSR_WAIT_TIMEOUT, 32'd10);
      queue_random(450, 8);
      drain();

      write_csr(CSR_VALID_PERIOD, 32'hffffffff);
      write_csr(CSR_WAIT_TIMEOUT, 32'd0);
      queue_random(150, 2);
      drain();

      write_csr(CSR_VALID_PERIOD, ValidPeriodReset);
      write_csr(CSR_WAIT_TIMEOUT, WaitTimeoutReset);
      queue_random(450, 200000);
      drain();

      $display("covered %0d commands and %0d register writes over five timeout settings",
               n_sent, n_cfg);
      $display("%0d results checked, %0d mismatches", n_checked, mismatches);
      if (mismatches == 0 && n_checked == n_sent)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
